FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low; the user module supplies both.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TWSPI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TWSPI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/twspi_pkg.sv
// ---------------------------------------------------------------------------
// twspi_pkg
// Shared types and codes of the three-wire SPI master.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package twspi_pkg;

    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LINES_W    = 5;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes on the command channel
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_W-1:0] OP_SEND  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_LINES = 2'd2;

    localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_RST  = 16'd60;
    localparam logic [CFG_DATA_W-1:0] SETTLE_RST       = 16'd100;
    localparam logic [LINES_W-1:0]    SELECT_LINES_RST = 5'd16;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_SEND,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_byte;
        logic       line_in;
    } cmd_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] half_period_ticks;
        logic [CFG_DATA_W-1:0] settle_ticks;
        logic [LINES_W-1:0]    select_lines_used;
    } twspi_cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

FILE: rtl/twspi_if.sv
// ---------------------------------------------------------------------------
// twspi interfaces
// Command, result and configuration channels, valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface twspi_cmd_if import twspi_pkg::*; #(parameter int NUM_SELECTS = 16) ();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [NUM_SELECTS-1:0] select_mask;
    logic [7:0]             tx_byte;
    logic                   line_in;

    modport source (output valid, operation, select_mask, tx_byte, line_in, input ready);
    modport sink   (input valid, operation, select_mask, tx_byte, line_in, output ready);
endinterface

interface twspi_res_if #(parameter int NUM_SELECTS = 16) ();
    logic                   valid;
    logic                   ready;
    logic                   clock_out;
    logic                   data_out;
    logic                   data_drive;
    logic [NUM_SELECTS-1:0] select_out;
    logic                   busy_res;
    logic                   rx_valid;
    logic [7:0]             rx_byte;
    logic                   rejected;

    modport source (output valid, clock_out, data_out, data_drive, select_out, busy_res,
                    rx_valid, rx_byte, rejected, input ready);
    modport sink   (input valid, clock_out, data_out, data_drive, select_out, busy_res,
                    rx_valid, rx_byte, rejected, output ready);
endinterface

interface twspi_cfg_if import twspi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/twspi_front.sv
// ---------------------------------------------------------------------------
// twspi_front
// Accept command beats, decode the operation and mask off absent selects.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twspi_front import twspi_pkg::*; #(
    parameter int NUM_SELECTS = 16
) (
    twspi_cmd_if.sink              cmd,
    input  twspi_cfg_t             cfg,
    input  q_status_t              q_stat,
    output logic                   push,
    output cmd_t                   push_cmd,
    output logic [NUM_SELECTS-1:0] push_mask
);

    logic [NUM_SELECTS-1:0] line_mask;

    assign cmd.ready = !q_stat.full;
    assign push      = cmd.valid && !q_stat.full;

    // Lines below the configured count are present
    always_comb
    begin
        for (int i = 0; i < NUM_SELECTS; i++)
        begin
            line_mask[i] = (LINES_W'(i) < cfg.select_lines_used);
        end
    end

    always_comb
    begin
        unique case (cmd.operation)
            OP_START: push_cmd.kind = CMD_START;
            OP_STOP:  push_cmd.kind = CMD_STOP;
            OP_SEND:  push_cmd.kind = CMD_SEND;
            OP_READ:  push_cmd.kind = CMD_READ;
            default:  push_cmd.kind = CMD_NONE;
        endcase
        push_cmd.tx_byte = cmd.tx_byte;
        push_cmd.line_in = cmd.line_in;
        push_mask        = cmd.select_mask & line_mask;
    end

endmodule

FILE: rtl/twspi_queue.sv
// ---------------------------------------------------------------------------
// twspi_queue
// Short FIFO between the decode front and the timing engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twspi_queue import twspi_pkg::*; #(
    parameter int WIDTH = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/twspi_back.sv
// ---------------------------------------------------------------------------
// twspi_back
// Timing engine: advance the serial bus by one cycle per queued beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twspi_back import twspi_pkg::*; #(
    parameter int NUM_SELECTS = 16,
    parameter int TIMER_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  twspi_cfg_t             cfg,
    input  q_status_t              q_stat,
    input  cmd_t                   pop_cmd,
    input  logic [NUM_SELECTS-1:0] pop_mask,
    output logic                   pop,
    twspi_res_if.source            res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_LOW,
        PH_HIGH
    } phase_t;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_DATA_W-1:0] v);
        if ({17'd0, v} > TIMER_MAX)
            timer_load = TIMER_MAX[TIMER_BITS-1:0];
        else
            timer_load = TIMER_BITS'(v);
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [2:0]             bit_count_reg, bit_count_next;
    logic [TIMER_BITS-1:0]  timer_reg, timer_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   clock_reg, clock_next;
    logic                   data_reg, data_next;
    logic                   drive_reg, drive_next;
    logic [NUM_SELECTS-1:0] select_reg, select_next;
    logic [NUM_SELECTS-1:0] pending_reg, pending_next;
    logic                   out_valid_reg;
    logic                   rx_valid_reg, rx_valid_next;
    logic [7:0]             rx_byte_reg, rx_byte_next;
    logic                   rejected_reg, rejected_next;

    logic [TIMER_BITS-1:0]  settle_load;
    logic [TIMER_BITS-1:0]  half_load;
    logic [CFG_DATA_W-1:0]  half_m1;
    logic                   is_cmd;

    // Advance only when the result slot is free or being emptied
    assign pop = !q_stat.empty && (!out_valid_reg || res.ready);

    assign half_m1     = (cfg.half_period_ticks == '0) ? '0 : cfg.half_period_ticks - 1'b1;
    assign half_load   = timer_load(half_m1);
    assign settle_load = timer_load(cfg.settle_ticks);
    assign is_cmd      = (pop_cmd.kind != CMD_NONE);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        timer_next     = timer_reg;
        shift_next     = shift_reg;
        clock_next     = clock_reg;
        data_next      = data_reg;
        drive_next     = drive_reg;
        select_next    = select_reg;
        pending_next   = pending_reg;
        rx_valid_next  = 1'b0;
        rx_byte_next   = 8'd0;
        rejected_next  = 1'b0;

        if (phase_reg != PH_IDLE)
        begin
            rejected_next = is_cmd;
            if (timer_reg != '0)
            begin
                timer_next = timer_reg - 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START_A:
                    begin
                        select_next = select_reg & ~pending_reg;
                        timer_next  = settle_load;
                        phase_next  = PH_START_B;
                    end
                    PH_STOP_A:
                    begin
                        select_next = select_reg | pending_reg;
                        timer_next  = settle_load;
                        phase_next  = PH_STOP_B;
                    end
                    PH_LOW:
                    begin
                        if (!drive_reg)
                        begin
                            shift_next = {shift_reg[6:0], pop_cmd.line_in};
                        end
                        clock_next = 1'b1;
                        timer_next = half_load;
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        clock_next = 1'b0;
                        if (bit_count_reg == 3'd7)
                        begin
                            if (!drive_reg)
                            begin
                                rx_valid_next = 1'b1;
                                rx_byte_next  = shift_reg;
                            end
                            bit_count_next = 3'd0;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 3'd1;
                            if (drive_reg)
                            begin
                                data_next = shift_reg[3'd6 - bit_count_reg];
                            end
                            timer_next = half_load;
                            phase_next = PH_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else
        begin
            unique case (pop_cmd.kind) inside
                CMD_START:
                begin
                    clock_next   = 1'b0;
                    data_next    = 1'b0;
                    drive_next   = 1'b1;
                    pending_next = pop_mask;
                    timer_next   = settle_load;
                    phase_next   = PH_START_A;
                end
                CMD_STOP:
                begin
                    pending_next = pop_mask;
                    timer_next   = settle_load;
                    phase_next   = PH_STOP_A;
                end
                CMD_SEND, CMD_READ:
                begin
                    clock_next     = 1'b0;
                    bit_count_next = 3'd0;
                    if (pop_cmd.kind == CMD_SEND)
                    begin
                        shift_next = pop_cmd.tx_byte;
                        drive_next = 1'b1;
                        data_next  = pop_cmd.tx_byte[7];
                    end
                    else
                    begin
                        shift_next = 8'd0;
                        drive_next = 1'b0;
                    end
                    timer_next = half_load;
                    phase_next = PH_LOW;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            timer_reg     <= '0;
            shift_reg     <= '0;
            clock_reg     <= 1'b1;
            data_reg      <= 1'b1;
            drive_reg     <= 1'b1;
            select_reg    <= '1;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            rx_valid_reg  <= 1'b0;
            rx_byte_reg   <= '0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                timer_reg     <= timer_next;
                shift_reg     <= shift_next;
                clock_reg     <= clock_next;
                data_reg      <= data_next;
                drive_reg     <= drive_next;
                select_reg    <= select_next;
                pending_reg   <= pending_next;
                rx_valid_reg  <= rx_valid_next;
                rx_byte_reg   <= rx_byte_next;
                rejected_reg  <= rejected_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Bus state only moves on a pop, so it always matches the pending result
    assign res.valid      = out_valid_reg;
    assign res.clock_out  = clock_reg;
    assign res.data_out   = data_reg;
    assign res.data_drive = drive_reg;
    assign res.select_out = select_reg;
    assign res.busy_res   = (phase_reg != PH_IDLE);
    assign res.rx_valid   = rx_valid_reg;
    assign res.rx_byte    = rx_byte_reg;
    assign res.rejected   = rejected_reg;

endmodule

FILE: rtl/three_wire_spi_master_unit.sv
// ---------------------------------------------------------------------------
// three_wire_spi_master_unit
// A command beat accepted from the command channel is written to the queue,
// then popped into the result registers once the result slot is free.
// Throughput: one beat per cycle while results are taken, set by the engine
// stepping once per beat.
// Reset: control state clears at once; clock, data and selects idle high,
// the data line is driven, configuration returns to 60 / 100 / 16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module three_wire_spi_master_unit import twspi_pkg::*; #(
    parameter int NUM_SELECTS = 16,
    parameter int TIMER_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    twspi_cmd_if.sink   cmd,
    twspi_res_if.source res,
    twspi_cfg_if.sink   cfg
);

    localparam int CMD_W   = $bits(cmd_t);
    localparam int ENTRY_W = CMD_W + NUM_SELECTS;

    twspi_cfg_t             cfg_reg, cfg_next;
    q_status_t              q_stat;
    logic                   q_push;
    logic                   q_pop;
    cmd_t                   push_cmd;
    logic [NUM_SELECTS-1:0] push_mask;
    logic [ENTRY_W-1:0]     pop_data;
    cmd_t                   pop_cmd;
    logic [NUM_SELECTS-1:0] pop_mask;

    // Configuration writes are taken every cycle; unknown indexes are ignored
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_HALF_PERIOD:  cfg_next.half_period_ticks = cfg.data;
                REG_SETTLE:       cfg_next.settle_ticks      = cfg.data;
                REG_SELECT_LINES: cfg_next.select_lines_used = cfg.data[LINES_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.settle_ticks      <= SETTLE_RST;
            cfg_reg.select_lines_used <= SELECT_LINES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: decode the operation, drop mask bits of absent select lines
    twspi_front #(
        .NUM_SELECTS (NUM_SELECTS)
    ) u_front (
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .push_mask (push_mask)
    );

    // Queue: lets the front keep taking beats while the result waits, until it is full
    twspi_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_mask, push_cmd}),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    assign pop_cmd  = pop_data[CMD_W-1:0];
    assign pop_mask = pop_data[ENTRY_W-1:CMD_W];

    // Back: step the serial timing engine one cycle per beat
    twspi_back #(
        .NUM_SELECTS (NUM_SELECTS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .pop_cmd  (pop_cmd),
        .pop_mask (pop_mask),
        .pop      (q_pop),
        .res      (res)
    );

    // A completed read leaves the line released and the engine idle
    `TWSPI_ASSERT_IMP(a_read_done, res.valid && res.rx_valid, !res.data_drive && !res.busy_res, "read completed while driving or busy")
    // The byte field is zero unless a read completes
    `TWSPI_ASSERT_IMP(a_rx_zero, res.valid && !res.rx_valid, res.rx_byte == 8'd0, "rx_byte set without rx_valid")
    // Every beat taken from the queue shows up as a result next cycle
    `TWSPI_ASSERT_NXT(a_pop_result, q_pop, res.valid, "popped beat produced no result")

endmodule

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench - three-wire SPI master unit
// Drives command beats, one per engine cycle, into the master and checks
// every result beat against a cycle model kept alongside the stimulus.
// Covers start, stop, send and read sequences, busy rejection, reserved
// opcodes and select line limits under several register settings and
// handshake idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import twspi_pkg::*;

    localparam int SEL_N = 16;

    // Reserved opcodes: the engine treats them like a no-op
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    // Line level choice for the line_in field of queued beats
    localparam int LINE_LOW  = 0;
    localparam int LINE_HIGH = 1;
    localparam int LINE_RAND = 2;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_START_A,
        ENG_START_B,
        ENG_STOP_A,
        ENG_STOP_B,
        ENG_LOW,
        ENG_HIGH
    } eng_phase_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [SEL_N-1:0] select_mask;
        logic [7:0]       tx_byte;
        logic             line_in;
    } spi_beat_t;

    typedef struct packed {
        logic             clock_out;
        logic             data_out;
        logic             data_drive;
        logic [SEL_N-1:0] select_out;
        logic             busy_res;
        logic             rx_valid;
        logic [7:0]       rx_byte;
        logic             rejected;
    } spi_pins_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    twspi_cmd_if #(.NUM_SELECTS(SEL_N)) cmd_if ();
    twspi_res_if #(.NUM_SELECTS(SEL_N)) res_if ();
    twspi_cfg_if                        cfg_if ();

    three_wire_spi_master_unit #(
        .NUM_SELECTS(SEL_N),
        .TIMER_BITS (16)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if.sink),
        .res  (res_if.source),
        .cfg  (cfg_if.sink)
    );

    // Register copies, updated at each accepted register write
    logic [15:0] cfg_half   = HALF_PERIOD_RST;
    logic [15:0] cfg_settle = SETTLE_RST;
    logic [4:0]  cfg_lines  = SELECT_LINES_RST;

    // Engine state as predicted, starting from its reset values
    eng_phase_t       eng_phase  = ENG_IDLE;
    logic [2:0]       bit_cnt    = '0;
    logic [15:0]      eng_timer  = '0;
    logic [7:0]       shreg      = '0;
    logic             sclk_lvl   = 1'b1;
    logic             sdata_lvl  = 1'b1;
    logic             sdrive_lvl = 1'b1;
    logic [SEL_N-1:0] cs_levels  = '1;
    logic [SEL_N-1:0] cs_pending = '0;

    spi_beat_t beat_backlog_q[$];
    spi_pins_t pins_expected_q[$];
    spi_beat_t cur_beat;
    spi_pins_t got_pins;
    spi_pins_t want_pins;

    int items_queued  = 0;
    int beats_sent    = 0;
    int results_seen  = 0;
    int reads_seen    = 0;
    int rejects_seen  = 0;
    int settings_used = 0;
    int mismatches    = 0;
    int fail_count    = 0;

    int send_idle_pct = 9;
    int recv_idle_pct = 64;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Engine model
    // -----------------------------------------------------------------------

    // Select lines that exist under the current line count, lowest first.
    function automatic logic [SEL_N-1:0] present_lines();
        int               n;
        logic [SEL_N-1:0] m;
        n = (cfg_lines > SEL_N) ? SEL_N : int'(cfg_lines);
        if (n >= SEL_N)
            m = '1;
        else
            m = SEL_N'((1 << n) - 1);
        return m;
    endfunction

    // A zero half period gives the same reload as a setting of one.
    function automatic logic [15:0] half_reload();
        return (cfg_half == 16'd0) ? 16'd0 : cfg_half - 16'd1;
    endfunction

    // Step the engine model with one beat and return the pin levels after it.
    function automatic spi_pins_t spi_engine_step(input spi_beat_t b);
        spi_pins_t r;
        logic      is_cmd;
        r = '0;
        is_cmd = (b.operation >= OP_START) && (b.operation <= OP_READ);
        if (eng_phase != ENG_IDLE)
        begin
            // Busy: drop any command and keep counting
            if (is_cmd)
                r.rejected = 1'b1;
            if (eng_timer != 16'd0)
                eng_timer = eng_timer - 16'd1;
            else
            begin
                case (eng_phase)
                    ENG_START_A:
                    begin
                        cs_levels = cs_levels & ~cs_pending;
                        eng_timer = cfg_settle;
                        eng_phase = ENG_START_B;
                    end
                    ENG_STOP_A:
                    begin
                        cs_levels = cs_levels | cs_pending;
                        eng_timer = cfg_settle;
                        eng_phase = ENG_STOP_B;
                    end
                    ENG_LOW:
                    begin
                        // Rising edge: a read samples the line here
                        if (!sdrive_lvl)
                            shreg = {shreg[6:0], b.line_in};
                        sclk_lvl  = 1'b1;
                        eng_timer = half_reload();
                        eng_phase = ENG_HIGH;
                    end
                    ENG_HIGH:
                    begin
                        sclk_lvl = 1'b0;
                        if (bit_cnt == 3'd7)
                        begin
                            if (!sdrive_lvl)
                            begin
                                r.rx_valid = 1'b1;
                                r.rx_byte  = shreg;
                            end
                            bit_cnt   = 3'd0;
                            eng_phase = ENG_IDLE;
                        end
                        else
                        begin
                            bit_cnt = bit_cnt + 3'd1;
                            if (sdrive_lvl)
                                sdata_lvl = shreg[3'd7 - bit_cnt];
                            eng_timer = half_reload();
                            eng_phase = ENG_LOW;
                        end
                    end
                    default:
                        eng_phase = ENG_IDLE;
                endcase
            end
        end
        else if (is_cmd)
        begin
            case (b.operation)
                OP_START:
                begin
                    sclk_lvl   = 1'b0;
                    sdata_lvl  = 1'b0;
                    sdrive_lvl = 1'b1;
                    cs_pending = b.select_mask & present_lines();
                    eng_timer  = cfg_settle;
                    eng_phase  = ENG_START_A;
                end
                OP_STOP:
                begin
                    cs_pending = b.select_mask & present_lines();
                    eng_timer  = cfg_settle;
                    eng_phase  = ENG_STOP_A;
                end
                default:
                begin
                    sclk_lvl = 1'b0;
                    bit_cnt  = 3'd0;
                    if (b.operation == OP_SEND)
                    begin
                        shreg      = b.tx_byte;
                        sdrive_lvl = 1'b1;
                        sdata_lvl  = b.tx_byte[7];
                    end
                    else
                    begin
                        shreg      = 8'd0;
                        sdrive_lvl = 1'b0;
                    end
                    eng_timer = half_reload();
                    eng_phase = ENG_LOW;
                end
            endcase
        end
        r.clock_out  = sclk_lvl;
        r.data_out   = sdata_lvl;
        r.data_drive = sdrive_lvl;
        r.select_out = cs_levels;
        r.busy_res   = (eng_phase != ENG_IDLE);
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Command driver: one beat per handshake, random gaps on the sender side
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_if.valid <= 1'b0;
        end
        else
        begin
            // Beat taken at this edge: step the model with it
            if (cmd_if.valid && cmd_if.ready)
            begin
                pins_expected_q.push_back(spi_engine_step(cur_beat));
                beats_sent++;
            end
            // Bus free: present the next beat or hold valid low
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (beat_backlog_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_beat = beat_backlog_q.pop_front();
                    cmd_if.valid       <= 1'b1;
                    cmd_if.operation   <= cur_beat.operation;
                    cmd_if.select_mask <= cur_beat.select_mask;
                    cmd_if.tx_byte     <= cur_beat.tx_byte;
                    cmd_if.line_in     <= cur_beat.line_in;
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: compare each result beat with the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got_pins.clock_out  = res_if.clock_out;
                got_pins.data_out   = res_if.data_out;
                got_pins.data_drive = res_if.data_drive;
                got_pins.select_out = res_if.select_out;
                got_pins.busy_res   = res_if.busy_res;
                got_pins.rx_valid   = res_if.rx_valid;
                got_pins.rx_byte    = res_if.rx_byte;
                got_pins.rejected   = res_if.rejected;
                results_seen++;
                if (got_pins.rx_valid === 1'b1)
                    reads_seen++;
                if (got_pins.rejected === 1'b1)
                    rejects_seen++;
                if (pins_expected_q.size() == 0)
                begin
                    fail_count++;
                    if (mismatches < 10)
                        $display("%0t: result beat %0d arrived with nothing predicted",
                                 $realtime, results_seen);
                    mismatches++;
                end
                else
                begin
                    want_pins = pins_expected_q.pop_front();
                    if (got_pins.clock_out  !== want_pins.clock_out  ||
                        got_pins.data_out   !== want_pins.data_out   ||
                        got_pins.data_drive !== want_pins.data_drive ||
                        got_pins.select_out !== want_pins.select_out ||
                        got_pins.busy_res   !== want_pins.busy_res   ||
                        got_pins.rx_valid   !== want_pins.rx_valid   ||
                        got_pins.rx_byte    !== want_pins.rx_byte    ||
                        got_pins.rejected   !== want_pins.rejected)
                    begin
                        fail_count++;
                        if (mismatches < 10)
                        begin
                            $display("%0t: result beat %0d mismatch", $realtime, results_seen);
                            $display("  exp sclk=%b sdo=%b drv=%b cs=%h busy=%b rxv=%b rx=%h rej=%b",
                                     want_pins.clock_out, want_pins.data_out,
                                     want_pins.data_drive, want_pins.select_out,
                                     want_pins.busy_res, want_pins.rx_valid,
                                     want_pins.rx_byte, want_pins.rejected);
                            $display("  got sclk=%b sdo=%b drv=%b cs=%h busy=%b rxv=%b rx=%h rej=%b",
                                     got_pins.clock_out, got_pins.data_out,
                                     got_pins.data_drive, got_pins.select_out,
                                     got_pins.busy_res, got_pins.rx_valid,
                                     got_pins.rx_byte, got_pins.rejected);
                        end
                        mismatches++;
                    end
                end
            end
            // Stall the result side at random
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic logic pick_line(input int sel);
        if (sel == LINE_LOW)
            return 1'b0;
        if (sel == LINE_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [SEL_N-1:0] pick_mask();
        logic [SEL_N-1:0] m;
        case ($urandom_range(0, 3))
            0:       m = '0;
            1:       m = '1;
            default: m = SEL_N'($urandom_range(0, 65535));
        endcase
        return m;
    endfunction

    // Engine cycles a command keeps the block busy after its own beat.
    function automatic int busy_span(input logic [OP_W-1:0] op);
        case (op)
            OP_START, OP_STOP: return 2 * int'(cfg_settle) + 2;
            OP_SEND, OP_READ:  return 16 * (int'(half_reload()) + 1);
            default:           return 0;
        endcase
    endfunction

    task automatic add_beat(input logic [OP_W-1:0] op, input logic [SEL_N-1:0] mask,
                            input logic [7:0] tx, input logic ln);
        spi_beat_t b;
        b.operation   = op;
        b.select_mask = mask;
        b.tx_byte     = tx;
        b.line_in     = ln;
        beat_backlog_q.push_back(b);
        items_queued++;
    endtask

    // Queue one command, then enough beats to carry it to completion. While
    // the block is surely busy, sprinkle in commands that must be dropped.
    task automatic add_transfer(input logic [OP_W-1:0] op, input logic [SEL_N-1:0] mask,
                                input logic [7:0] tx, input int noise_pct, input int line_sel);
        int               span;
        int               tail;
        int               k;
        logic [OP_W-1:0]  fop;
        span = busy_span(op);
        tail = span + $urandom_range(0, 2);
        add_beat(op, mask, tx, pick_line(line_sel));
        for (k = 0; k < tail; k++)
        begin
            fop = OP_NONE;
            if (k < span && $urandom_range(0, 99) < noise_pct)
                fop = OP_W'($urandom_range(OP_START, OP_RSVD7));
            add_beat(fop, pick_mask(), 8'($urandom_range(0, 255)), pick_line(line_sel));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_HALF_PERIOD:  cfg_half   = val;
            REG_SETTLE:       cfg_settle = val;
            REG_SELECT_LINES: cfg_lines  = val[4:0];
            default:          ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] half, input logic [15:0] settle,
                                 input logic [4:0] lines);
        write_reg(REG_HALF_PERIOD, half);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_SELECT_LINES, {11'd0, lines});
        settings_used++;
    endtask

    // Wait until every queued beat is taken and every result checked, top up
    // with no-ops if the model is still mid-command, then let the pipe empty.
    task automatic drain_block(input int pause);
        while (1)
        begin
            while (beats_sent != items_queued || pins_expected_q.size() != 0)
                @(posedge clk);
            if (eng_phase == ENG_IDLE)
                break;
            add_beat(OP_NONE, '0, 8'd0, 1'b0);
        end
        repeat (pause) @(posedge clk);
    endtask

    // Mostly well-formed start / transfers / stop sequences with random
    // content, with an occasional burst of arbitrary beats.
    task automatic run_random(input int budget);
        int stop_at;
        stop_at = items_queued + budget;
        while (items_queued < stop_at)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                add_transfer(OP_START, pick_mask(), 8'($urandom_range(0, 255)), 5, LINE_RAND);
                repeat ($urandom_range(1, 4))
                    add_transfer($urandom_range(0, 1) ? OP_SEND : OP_READ, pick_mask(),
                                 8'($urandom_range(0, 255)), 5, $urandom_range(0, 2));
                add_transfer(OP_STOP, pick_mask(), 8'($urandom_range(0, 255)), 5, LINE_RAND);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    add_beat(OP_W'($urandom_range(OP_NONE, OP_RSVD7)), pick_mask(),
                             8'($urandom_range(0, 255)), pick_line(LINE_RAND));
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        cmd_if.valid       = 1'b0;
        cmd_if.operation   = OP_NONE;
        cmd_if.select_mask = '0;
        cmd_if.tx_byte     = 8'd0;
        cmd_if.line_in     = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_HALF_PERIOD;
        cfg_if.data        = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Idling pattern one: light sender gaps, heavy result stalls
        send_idle_pct = 9;
        recv_idle_pct = 64;

        // Directed: short timing so each case finishes quickly
        apply_setting(16'd2, 16'd1, 5'd16);
        add_transfer(OP_START, '1, 8'h00, 0, LINE_RAND);
        add_transfer(OP_SEND, '0, 8'hFF, 0, LINE_RAND);
        add_transfer(OP_SEND, '1, 8'h00, 0, LINE_RAND);
        add_transfer(OP_READ, '0, 8'h00, 0, LINE_HIGH);
        add_transfer(OP_READ, '0, 8'hFF, 0, LINE_LOW);
        // Send right after a read takes the line back
        add_transfer(OP_SEND, '0, 8'hA5, 0, LINE_RAND);
        add_transfer(OP_READ, '0, 8'h00, 0, LINE_RAND);
        add_transfer(OP_STOP, '1, 8'h00, 0, LINE_RAND);
        // Reserved opcodes while idle
        add_beat(OP_RSVD5, '1, 8'hFF, 1'b1);
        add_beat(OP_RSVD6, '1, 8'hFF, 1'b1);
        add_beat(OP_RSVD7, '1, 8'hFF, 1'b1);
        // Every command, and a reserved code, while a send is in flight
        add_beat(OP_SEND, '0, 8'h3C, 1'b0);
        add_beat(OP_START, '1, 8'hFF, 1'b1);
        add_beat(OP_STOP, '1, 8'hFF, 1'b1);
        add_beat(OP_SEND, '1, 8'hFF, 1'b1);
        add_beat(OP_READ, '1, 8'hFF, 1'b1);
        add_beat(OP_RSVD5, '1, 8'hFF, 1'b1);
        repeat (busy_span(OP_SEND) - 4)
            add_beat(OP_NONE, '0, 8'h00, 1'b0);
        // Read leaves the line released until the next start
        add_transfer(OP_READ, '0, 8'h00, 0, LINE_RAND);
        add_transfer(OP_START, 16'h8001, 8'h00, 0, LINE_RAND);
        add_transfer(OP_STOP, 16'h0001, 8'h00, 0, LINE_RAND);
        drain_block(4);

        // Zero half period and settle, no select lines present
        apply_setting(16'd0, 16'd0, 5'd0);
        add_transfer(OP_START, '1, 8'h00, 0, LINE_RAND);
        add_transfer(OP_SEND, '0, 8'h81, 0, LINE_RAND);
        add_transfer(OP_STOP, '1, 8'h00, 0, LINE_RAND);
        drain_block(4);

        // More lines requested than exist
        apply_setting(16'd1, 16'd0, 5'd20);
        add_transfer(OP_START, '1, 8'h00, 0, LINE_RAND);
        add_transfer(OP_STOP, 16'h5555, 8'h00, 0, LINE_RAND);
        drain_block(4);

        // Random part
        apply_setting(16'd1, 16'd0, 5'd16);
        run_random(80);
        drain_block(4);
        apply_setting(16'd2, 16'd2, 5'd7);
        run_random(80);
        drain_block(4);

        // Idling pattern two: swap the sides
        send_idle_pct = 64;
        recv_idle_pct = 9;
        apply_setting(16'd0, 16'd5, 5'd31);
        run_random(80);
        drain_block(4);
        apply_setting(16'd1, 16'd0, 5'd0);
        run_random(80);
        drain_block(4);

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(16'd3, 16'd3, 5'd17);
        run_random(80);
        drain_block(4);

        // Top half period, one select line: one start with drops along the way
        apply_setting(16'hFFFF, 16'd40, 5'd1);
        add_transfer(OP_START, pick_mask(), 8'h00, 2, LINE_RAND);
        drain_block(8);

        fail_count += pins_expected_q.size();
        $display("Checked %0d result beats over %0d register settings", results_seen,
                 settings_used);
        $display("Bytes read: %0d, commands dropped while busy: %0d, mismatches: %0d",
                 reads_seen, rejects_seen, mismatches);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/twspi_pkg.sv
rtl/twspi_if.sv
rtl/twspi_front.sv
rtl/twspi_queue.sv
rtl/twspi_back.sv
rtl/three_wire_spi_master_unit.sv
test/testbench.sv
